/* rtl/hfr_pkg.sv */
// ----------------------------------------------------------------------------
// hfr_pkg
// Shared constants, types and the CRC-16/X.25 byte step for the HDLC frame
// receiver.
// ----------------------------------------------------------------------------
package hfr_pkg;

  localparam int FRAME_BYTES = 64;
  localparam int ADDR_W      = $clog2(FRAME_BYTES);

  localparam logic [7:0]  FLAG_OCTET    = 8'h7E;
  localparam logic [7:0]  ESC_OCTET     = 8'h7D;
  localparam logic [7:0]  XOR_OCTET     = 8'h20;
  localparam int          OPEN_ZONE     = 9;
  localparam int          TRAILER_BYTES = 3;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;

  typedef enum logic [1:0] {
    S_RECV,
    S_CHECK,
    S_EMIT_RD,
    S_EMIT_LD
  } hfr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rx_accept;
    logic chk_step;
    logic emit_start;
    logic emit_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic close_hit;
    logic chk_done;
    logic out_free;
    logic emit_last;
  } dp_sts_t;

  // One byte of reflected CRC-16/X.25, bit by bit.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/hfr_rx_if.sv */
// ----------------------------------------------------------------------------
// hfr_rx_if
// Valid/ready channel that carries one received line byte per item.
// ----------------------------------------------------------------------------
interface hfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/hfr_out_if.sv */
// ----------------------------------------------------------------------------
// hfr_out_if
// Valid/ready channel that carries one content byte of a closed frame per item.
// ----------------------------------------------------------------------------
interface hfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_ok;
  logic       last_byte;

  modport source (output valid, output out_byte, output frame_ok, output last_byte,
                  input ready);
  modport sink   (input valid, input out_byte, input frame_ok, input last_byte,
                  output ready);
endinterface

/* rtl/hfr_ram.sv */
// ----------------------------------------------------------------------------
// hfr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/hfr_datapath.sv */
// ----------------------------------------------------------------------------
// hfr_datapath
// Frame store, byte unstuffing, FCS check pass and the result register.
// ----------------------------------------------------------------------------
module hfr_datapath import hfr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  input  logic        res_ready,
  output logic        res_valid,
  output logic [7:0]  out_byte,
  output logic        frame_ok,
  output logic        last_byte
);

  localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(FRAME_BYTES - 1);
  localparam logic [ADDR_W-1:0] POS_OPEN = ADDR_W'(OPEN_ZONE);
  localparam logic [ADDR_W-1:0] POS_ONE  = ADDR_W'(1);

  logic [ADDR_W-1:0] wp, wp_next;
  logic              esc, esc_next;
  logic [ADDR_W-1:0] end_pos;
  logic [ADDR_W-1:0] rd_ptr;
  logic [ADDR_W-1:0] chk_addr;
  logic              chk_vld;
  logic [15:0]       crc;
  logic [7:0]        fcs_lo;
  logic              ok;

  logic              wr_en;
  logic [7:0]        wr_data;
  logic [7:0]        rd_data;
  logic              store;
  logic              flag_hit;
  logic [ADDR_W-1:0] content_len;
  logic              chk_last;

  hfr_ram #(
    .WIDTH(8),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wp),
    .wr_data(wr_data),
    .rd_addr(rd_ptr),
    .rd_data(rd_data)
  );

  assign flag_hit    = (rx_byte == FLAG_OCTET) && !esc;
  assign content_len = end_pos - ADDR_W'(TRAILER_BYTES);
  assign chk_last    = chk_vld && (chk_addr == end_pos - POS_ONE);

  assign sts.close_hit = flag_hit && (wp >= POS_OPEN);
  assign sts.chk_done  = chk_last;
  assign sts.out_free  = !res_valid || res_ready;
  assign sts.emit_last = (rd_ptr == content_len);

  // Receive path: flags near the frame start are data (a repeated flag at
  // position 1 is dropped), escapes only count once the open zone is passed.
  always_comb begin
    store    = 1'b0;
    wr_data  = rx_byte;
    wp_next  = wp;
    esc_next = esc;
    if (cmd.rx_accept) begin
      if (flag_hit) begin
        store = (wp != POS_ONE) && (wp < POS_OPEN);
      end else if (esc) begin
        store    = 1'b1;
        wr_data  = rx_byte ^ XOR_OCTET;
        esc_next = 1'b0;
      end else if ((rx_byte == ESC_OCTET) && (wp >= POS_OPEN)) begin
        esc_next = 1'b1;
      end else begin
        store = 1'b1;
      end
    end
    if (store) begin
      if (wp == POS_LAST) begin
        wp_next  = '0;
        esc_next = 1'b0;
      end else begin
        wp_next = wp + POS_ONE;
      end
    end
    if (cmd.rx_accept && sts.close_hit) begin
      wp_next = '0;
    end
    wr_en = store;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      esc <= 1'b0;
    end else begin
      wp  <= wp_next;
      esc <= esc_next;
    end
  end

  // Read pointer sweeps the store twice: once for the check, once to emit.
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_vld <= 1'b0;
    end else if (cmd.rx_accept && sts.close_hit) begin
      chk_vld <= 1'b0;
    end else if (cmd.chk_step && !cmd.emit_start) begin
      chk_vld <= (rd_ptr != end_pos);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rx_accept && sts.close_hit) begin
      end_pos <= wp;
      rd_ptr  <= POS_ONE;
      crc     <= CRC_INIT;
    end else if (cmd.emit_start) begin
      rd_ptr <= POS_ONE;
    end else if (cmd.chk_step) begin
      chk_addr <= rd_ptr;
      if (rd_ptr != end_pos) begin
        rd_ptr <= rd_ptr + POS_ONE;
      end
    end else if (cmd.emit_load) begin
      rd_ptr <= rd_ptr + POS_ONE;
    end

    if (cmd.chk_step && chk_vld) begin
      if (chk_addr <= content_len) begin
        crc <= crc_byte(crc, rd_data);
      end
      if (chk_addr == end_pos - ADDR_W'(2)) begin
        fcs_lo <= rd_data;
      end
      // The high FCS byte is the last one read; the CRC is final by then.
      if (chk_last) begin
        ok <= ((crc ^ 16'hFFFF) == {rd_data, fcs_lo});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      out_byte  <= rd_data;
      frame_ok  <= ok;
      last_byte <= sts.emit_last;
    end
  end

endmodule

/* rtl/hfr_controller.sv */
// ----------------------------------------------------------------------------
// hfr_controller
// Sequencer for receive, check and emit phases of a frame.
// ----------------------------------------------------------------------------
module hfr_controller import hfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    rx_valid,
  output logic    rx_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  hfr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_RECV: begin
        if (rx_valid && sts.close_hit) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.chk_done) begin
          state_next = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          state_next = sts.emit_last ? S_RECV : S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_RECV;
      end
    endcase
  end

  always_comb begin
    rx_ready       = 1'b0;
    cmd.rx_accept  = 1'b0;
    cmd.chk_step   = 1'b0;
    cmd.emit_start = 1'b0;
    cmd.emit_load  = 1'b0;
    unique case (state)
      S_RECV: begin
        rx_ready      = 1'b1;
        cmd.rx_accept = rx_valid;
      end
      S_CHECK: begin
        cmd.chk_step   = 1'b1;
        cmd.emit_start = sts.chk_done;
      end
      S_EMIT_RD: begin
      end
      S_EMIT_LD: begin
        cmd.emit_load = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/hdlc_frame_receiver_fcs16.sv */
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_fcs16
// HDLC deframer with byte unstuffing and CRC-16/X.25 frame check.
//
//   Channel   Direction  Payload                          Item
//   rx        in         rx_byte[7:0]                     one line byte
//   res       out        out_byte[7:0], frame_ok,         one content byte
//                        last_byte
//
// Line bytes are taken one per cycle while a frame is being received.
// A closing flag at position p starts a check pass through the single read
// port of the frame store, then each of the p-3 content bytes goes through
// a store read, then a result register load.
// Input is held off from the closing flag until the last result is loaded.
// Reset is synchronous; no store clearing pass is needed.
// Stalls on the result side hold the emit sequence in place.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver_fcs16 import hfr_pkg::*; (
  input logic   clk,
  input logic   rst,
  hfr_rx_if.sink    rx,
  hfr_out_if.source res
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  hfr_controller u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .rx_valid(rx.valid),
    .rx_ready(rx.ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  hfr_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx.rx_byte),
    .cmd      (cmd),
    .sts      (sts),
    .res_ready(res.ready),
    .res_valid(res.valid),
    .out_byte (res.out_byte),
    .frame_ok (res.frame_ok),
    .last_byte(res.last_byte)
  );

endmodule

/* rtl/hfr_checker.sv */
// ----------------------------------------------------------------------------
// hfr_port_checker
// Port-level checks for the HDLC frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module hfr_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] out_byte,
  input logic       frame_ok,
  input logic       last_byte
);

  // A stalled result keeps its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(out_byte) &&
      $stable(frame_ok) && $stable(last_byte))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid right after reset");

  // While a frame is still being emitted, no line byte is taken.
  a_no_rx_mid_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last_byte |-> !rx_ready)
    else $error("input ready in the middle of a frame burst");

  // Input ready only drops after a byte has been taken.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    rx_ready && !rx_valid |=> rx_ready)
    else $error("input ready dropped without an accepted item");

  // A new result that is not the end of its frame never shows up while
  // line bytes are being taken.
  a_rise_blocks_rx: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) && !last_byte |-> !rx_ready)
    else $error("result appeared while receiving");

endmodule

bind hdlc_frame_receiver_fcs16 hfr_port_checker u_hfr_checker (
  .clk      (clk),
  .rst      (rst),
  .rx_valid (rx.valid),
  .rx_ready (rx.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .out_byte (res.out_byte),
  .frame_ok (res.frame_ok),
  .last_byte(res.last_byte)
);

/* tb/hfr_checker.sv */
// ----------------------------------------------------------------------------
// hfr_checker
// Watches the line-byte and result channels of the HDLC frame receiver. It
// keeps its own frame store, unstuffs and closes frames the way the receiver
// must, and compares every result with the oldest expected content byte.
// ----------------------------------------------------------------------------
module hfr_checker import hfr_pkg::*; (
  input  logic clk,
  input  logic rst,
  hfr_rx_if    rx,
  hfr_out_if   res,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] octet;
    logic       fcs_ok;
    logic       last;
  } content_t;

  logic [7:0] frame_mem [FRAME_BYTES];
  logic [6:0] fill_pos;
  logic       unstuff_next;
  content_t   content_q [$];
  content_t   want;

  function automatic void log_failure(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%t: %s", $realtime, msg);
    end
  endfunction

  // Advances the frame state by one line byte and queues the content bytes
  // of a frame that it closes.
  function automatic void absorb_line_byte(input logic [7:0] line_byte);
    logic [7:0]  b;
    logic [15:0] crc;
    logic        ok;
    int          p;
    int          n;
    content_t    r;
    b = line_byte;
    if (b == FLAG_OCTET && !unstuff_next) begin
      p = fill_pos;
      if (p == 1) begin
        return;
      end
      frame_mem[p] = b;
      if (p < OPEN_ZONE) begin
        fill_pos = fill_pos + 7'd1;
        return;
      end
      n = p - TRAILER_BYTES;
      crc = CRC_INIT;
      for (int i = 1; i <= n; i++) begin
        crc = crc ^ {8'h00, frame_mem[i]};
        repeat (8) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY_REFL) : (crc >> 1);
      end
      // The check sequence sits just before the closing flag, low byte first.
      ok = (~crc == {frame_mem[p-1], frame_mem[p-2]});
      for (int i = 1; i <= n; i++) begin
        r.octet  = frame_mem[i];
        r.fcs_ok = ok;
        r.last   = (i == n);
        content_q.push_back(r);
      end
      fill_pos = '0;
      return;
    end
    if (unstuff_next) begin
      unstuff_next = 1'b0;
      b = b ^ XOR_OCTET;
    end else if (b == ESC_OCTET && fill_pos >= OPEN_ZONE) begin
      unstuff_next = 1'b1;
      return;
    end
    frame_mem[fill_pos] = b;
    fill_pos = fill_pos + 7'd1;
    if (fill_pos >= FRAME_BYTES) begin
      fill_pos = '0;
      unstuff_next = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      fill_pos = '0;
      unstuff_next = 1'b0;
      content_q.delete();
    end else begin
      if (rx.valid && rx.ready) begin
        absorb_line_byte(rx.rx_byte);
      end
      if (res.valid && res.ready) begin
        if (content_q.size() == 0) begin
          log_failure($sformatf("result with nothing expected: byte %02h ok %0d last %0d",
                                res.out_byte, res.frame_ok, res.last_byte));
        end else begin
          want = content_q.pop_front();
          if (res.out_byte !== want.octet || res.frame_ok !== want.fcs_ok ||
              res.last_byte !== want.last) begin
            log_failure($sformatf({"mismatch: expected byte %02h ok %0d last %0d, ",
                                   "got byte %02h ok %0d last %0d"},
                                  want.octet, want.fcs_ok, want.last,
                                  res.out_byte, res.frame_ok, res.last_byte));
          end
        end
      end
    end
    outstanding = content_q.size();
  end

endmodule

/* tb/hdlc_frame_receiver_fcs16_test.sv */
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_fcs16_test
// Drives stuffed HDLC line bytes into the frame receiver: directed frames for
// the flag and escape corner cases, then random good and corrupted frames,
// overruns and line noise, with random idling on both channels. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver_fcs16_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hfr_pkg::*;

  typedef logic [7:0] octet_q_t [$];

  localparam int RANDOM_ITEMS = 480;

  logic clk = 1'b0;
  logic rst;
  int   errors;
  int   outstanding;

  hfr_rx_if  rx_ch ();
  hfr_out_if res_ch ();

  hdlc_frame_receiver_fcs16 DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  hfr_checker frame_check (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_ch),
    .res         (res_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // Line bytes waiting to go out, and where the receiver will stand once
  // they are all taken.
  logic [7:0] line_q [$];
  int         line_pos = 0;
  logic       line_esc = 1'b0;
  int         sent_items = 0;
  bit         calm = 1'b0;
  bit         gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [15:0] fcs_of(input octet_q_t body);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) begin
      c = c ^ {8'h00, body[i]};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return ~c;
  endfunction

  function automatic logic [7:0] pick_octet();
    if ($urandom_range(0, 7) == 0) begin
      return $urandom_range(0, 1) ? FLAG_OCTET : ESC_OCTET;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] plain_octet();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    return (v == FLAG_OCTET) ? 8'h00 : v;
  endfunction

  // A repeated flag at position 1 is ignored and does not count as an item.
  function automatic void line_push(input logic [7:0] b);
    line_q.push_back(b);
    if (b == FLAG_OCTET && !line_esc) begin
      if (line_pos == 1) begin
        return;
      end
      sent_items++;
      line_pos = (line_pos < OPEN_ZONE) ? line_pos + 1 : 0;
      return;
    end
    sent_items++;
    if (line_esc) begin
      line_esc = 1'b0;
    end else if (b == ESC_OCTET && line_pos >= OPEN_ZONE) begin
      line_esc = 1'b1;
      return;
    end
    line_pos++;
    if (line_pos >= FRAME_BYTES) begin
      line_pos = 0;
      line_esc = 1'b0;
    end
  endfunction

  // Escaping only takes effect past the open zone; there, ordinary bytes are
  // sometimes escaped as well.
  function automatic void stuff_octet(input logic [7:0] v);
    if (line_pos >= OPEN_ZONE &&
        (v == FLAG_OCTET || v == ESC_OCTET || $urandom_range(0, 7) == 0)) begin
      line_push(ESC_OCTET);
      line_push(v ^ XOR_OCTET);
    end else begin
      line_push(v);
    end
  endfunction

  function automatic void queue_frame(input octet_q_t body, input bit fcs_good,
                                      input bit dup_flag);
    logic [15:0] fcs;
    if (body[0] == FLAG_OCTET) begin
      body[0] = 8'h7F;
    end
    fcs = fcs_of(body);
    if (!fcs_good) begin
      fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
    end
    body.push_back(fcs[7:0]);
    body.push_back(fcs[15:8]);
    line_push(FLAG_OCTET);
    if (dup_flag) begin
      line_push(FLAG_OCTET);
    end
    foreach (body[i]) begin
      stuff_octet(body[i]);
    end
    line_push(FLAG_OCTET);
  endfunction

  // Fills the store without a closing flag until the frame is dropped.
  function automatic void queue_overrun();
    line_push(FLAG_OCTET);
    do begin
      stuff_octet(pick_octet());
    end while (line_pos != 0);
  endfunction

  // Random bytes rich in flags and escapes, then enough filler and a flag
  // to bring the receiver back to the start of a frame.
  function automatic void queue_noise();
    repeat ($urandom_range(1, 20)) begin
      line_push($urandom_range(0, 2) == 0 ? pick_octet() :
                ($urandom_range(0, 1) ? FLAG_OCTET : ESC_OCTET));
    end
    while (line_pos != 0) begin
      if (line_esc || line_pos < OPEN_ZONE) begin
        line_push(plain_octet());
      end else begin
        line_push(FLAG_OCTET);
      end
    end
  endfunction

  task automatic send_line();
    while (line_q.size() != 0) begin
      if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
        rx_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      rx_ch.valid   <= 1'b1;
      rx_ch.rx_byte <= line_q.pop_front();
      do @(posedge clk); while (!rx_ch.ready);
    end
  endtask

  task automatic hold_until_drained();
    rx_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin
    octet_q_t body;
    int       len;
    int       pick;
    int       n_frame;
    int       stop_at;
    rst           <= 1'b1;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Shortest frame with a repeated opening flag; early flags and early
    // escape bytes in the content are plain data.
    queue_frame('{8'hFF, ESC_OCTET, FLAG_OCTET, 8'h00, FLAG_OCTET, ESC_OCTET}, 1'b1, 1'b1);
    // Corrupted check sequence, and a flag escaped past the open zone.
    queue_frame('{8'h00, 8'hFF, 8'h80, 8'h01, ESC_OCTET, 8'hAA, 8'h55, 8'hFE, FLAG_OCTET},
                1'b0, 1'b0);
    send_line();
    hold_until_drained();

    stop_at = sent_items + RANDOM_ITEMS;
    n_frame = 0;
    while (sent_items < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      calm    = (sent_items > stop_at - 80);
      pick    = $urandom_range(0, 19);
      if (n_frame == 2 || (pick == 0 && n_frame > 2)) begin
        queue_overrun();
      end else if (pick <= 2 && n_frame > 2) begin
        queue_noise();
      end else begin
        if (n_frame == 0) begin
          len = FRAME_BYTES - 4;
        end else if (n_frame == 1) begin
          len = 6;
        end else if (pick < 16) begin
          len = $urandom_range(6, 14);
        end else if (pick < 19) begin
          len = $urandom_range(15, 40);
        end else begin
          len = $urandom_range(41, FRAME_BYTES - 4);
        end
        body = {};
        repeat (len) body.push_back(pick_octet());
        queue_frame(body, $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
      end
      send_line();
      if (!calm && $urandom_range(0, 9) == 0) begin
        hold_until_drained();
      end
      n_frame++;
    end

    hold_until_drained();
    repeat (2 * FRAME_BYTES + 16) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
